### design/bcc_pkg.sv
// Shared constants for the barycentric coordinate unit.
`default_nettype none

package bcc_pkg;

    // Weight format: signed Q4.12
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 12;
    // Unsigned quotient bits before the sign is applied
    localparam int QUOT_BITS   = 15;
    // Shift that sets the saturation bound: area * 8 equals 32768 / 4096
    localparam int SAT_SHIFT   = 3;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 16'h7FFF;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN = 16'h8000;

endpackage

`default_nettype wire

### design/bcc_cross.sv
// Two-stage 2D cross product x0*z1 - z0*x1 of signed differences.
`default_nettype none

module bcc_cross #(
    parameter int DIFF_BITS = 17
) (
    input  wire logic                          clk,
    input  wire logic                          ce,
    input  wire logic signed [DIFF_BITS-1:0]   x0,
    input  wire logic signed [DIFF_BITS-1:0]   z0,
    input  wire logic signed [DIFF_BITS-1:0]   x1,
    input  wire logic signed [DIFF_BITS-1:0]   z1,
    output logic signed [2*DIFF_BITS-1:0]      cross_out
);

    localparam int PW = 2 * DIFF_BITS;

    logic signed [PW-1:0] prod_a_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [PW-1:0] cross_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_a_reg <= x0 * z1;
            prod_b_reg <= z0 * x1;
            cross_reg  <= prod_a_reg - prod_b_reg;
        end
    end

    assign cross_out = cross_reg;

endmodule

`default_nettype wire

### design/bcc_div_lane.sv
// Pipelined restoring divider: trunc(num * 4096 / area), saturated to Q4.12.
`default_nettype none

module bcc_div_lane #(
    parameter int MAG_BITS = 34
) (
    input  wire logic                              clk,
    input  wire logic                              ce,
    input  wire logic signed [MAG_BITS-1:0]        num,
    input  wire logic        [MAG_BITS-1:0]        area,
    output logic [bcc_pkg::WEIGHT_BITS-1:0]        weight
);

    localparam int QB = bcc_pkg::QUOT_BITS;
    localparam int DW = MAG_BITS + bcc_pkg::FRAC_BITS + bcc_pkg::SAT_SHIFT;

    logic [MAG_BITS-1:0] mag;
    logic                sat;

    logic [DW-1:0]       rem_reg  [0:QB];
    logic [MAG_BITS-1:0] area_reg [0:QB];
    logic [QB-1:0]       quot_reg [0:QB];
    logic                neg_reg  [0:QB];
    logic                sat_reg  [0:QB];
    logic [bcc_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic [bcc_pkg::WEIGHT_BITS-1:0] weight_next;

    assign mag = num[MAG_BITS-1] ? (~num + 1'b1) : num;
    assign sat = {{bcc_pkg::SAT_SHIFT{1'b0}}, mag} >=
                 {area, {bcc_pkg::SAT_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0]  <= {{bcc_pkg::SAT_SHIFT{1'b0}}, mag, {bcc_pkg::FRAC_BITS{1'b0}}};
            area_reg[0] <= area;
            quot_reg[0] <= '0;
            neg_reg[0]  <= num[MAG_BITS-1];
            sat_reg[0]  <= sat;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DW-1:0] trial;
        logic          fits;

        assign trial = {{(DW-MAG_BITS){1'b0}}, area_reg[k-1]} << (QB - k);
        assign fits  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k]  <= fits ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                quot_reg[k] <= quot_reg[k-1] | (QB'(fits) << (QB - k));
                area_reg[k] <= area_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (sat_reg[QB])
            weight_next = neg_reg[QB] ? bcc_pkg::WEIGHT_MIN : bcc_pkg::WEIGHT_MAX;
        else if (neg_reg[QB])
            weight_next = ~{1'b0, quot_reg[QB]} + 1'b1;
        else
            weight_next = {1'b0, quot_reg[QB]};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            weight_reg <= weight_next;
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

### design/triangle_barycentric_coords_unit.sv
// Throughput: one request per cycle when the output is not stalled; the divider
// lanes set the depth.
// A stall at the output holds the whole pipeline; the input is ready again as
// soon as the output register is taken or empty.
// Reset (rst_n low, asynchronous) clears the valid bits only; the data registers are not reset.
`default_nettype none

module triangle_barycentric_coords_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_x, point_z, vert_a_x, vert_a_z, vert_b_x, vert_b_z, vert_c_x, vert_c_z
    input  wire logic [8*COORD_BITS-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // weight_u, weight_v, weight_w
    output logic [3*bcc_pkg::WEIGHT_BITS-1:0] m_axis_tdata,
    // degenerate
    output logic                          m_axis_tuser
);

    localparam int DB   = COORD_BITS + 1;
    localparam int CW   = 2 * DB;
    localparam int LDIV = bcc_pkg::QUOT_BITS + 2;
    localparam int LAT  = 3 + LDIV;

    logic ce;
    logic vld_reg [0:LAT-1];
    logic deg_reg [0:LDIV-1];

    logic signed [COORD_BITS-1:0] px, pz, ax, az, bx, bz, cx, cz;

    logic signed [DB-1:0] bax_reg, baz_reg, cax_reg, caz_reg;
    logic signed [DB-1:0] bpx_reg, bpz_reg, cpx_reg, cpz_reg, apx_reg, apz_reg;

    logic signed [CW-1:0] area_cross, u_cross, v_cross, w_cross;
    logic        [CW-1:0] area_mag;
    logic [bcc_pkg::WEIGHT_BITS-1:0] wu, wv, ww;

    assign ce            = !(vld_reg[LAT-1] && !m_axis_tready);
    assign s_axis_tready = ce;

    assign px = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign pz = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign ax = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign az = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    assign bx = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    assign bz = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
    assign cx = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
    assign cz = s_axis_tdata[7*COORD_BITS +: COORD_BITS];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            bax_reg <= DB'(bx) - DB'(ax);
            baz_reg <= DB'(bz) - DB'(az);
            cax_reg <= DB'(cx) - DB'(ax);
            caz_reg <= DB'(cz) - DB'(az);
            bpx_reg <= DB'(bx) - DB'(px);
            bpz_reg <= DB'(bz) - DB'(pz);
            cpx_reg <= DB'(cx) - DB'(px);
            cpz_reg <= DB'(cz) - DB'(pz);
            apx_reg <= DB'(ax) - DB'(px);
            apz_reg <= DB'(az) - DB'(pz);
        end
    end

    bcc_cross #(.DIFF_BITS(DB)) u_area (
        .clk(clk), .ce(ce),
        .x0(bax_reg), .z0(baz_reg), .x1(cax_reg), .z1(caz_reg), .cross_out(area_cross)
    );

    bcc_cross #(.DIFF_BITS(DB)) u_num_u (
        .clk(clk), .ce(ce),
        .x0(bpx_reg), .z0(bpz_reg), .x1(cpx_reg), .z1(cpz_reg), .cross_out(u_cross)
    );

    bcc_cross #(.DIFF_BITS(DB)) u_num_v (
        .clk(clk), .ce(ce),
        .x0(cpx_reg), .z0(cpz_reg), .x1(apx_reg), .z1(apz_reg), .cross_out(v_cross)
    );

    bcc_cross #(.DIFF_BITS(DB)) u_num_w (
        .clk(clk), .ce(ce),
        .x0(apx_reg), .z0(apz_reg), .x1(bpx_reg), .z1(bpz_reg), .cross_out(w_cross)
    );

    assign area_mag = area_cross[CW-1] ? (~area_cross + 1'b1) : area_cross;

    bcc_div_lane #(.MAG_BITS(CW)) u_div_u (
        .clk(clk), .ce(ce), .num(u_cross), .area(area_mag), .weight(wu)
    );

    bcc_div_lane #(.MAG_BITS(CW)) u_div_v (
        .clk(clk), .ce(ce), .num(v_cross), .area(area_mag), .weight(wv)
    );

    bcc_div_lane #(.MAG_BITS(CW)) u_div_w (
        .clk(clk), .ce(ce), .num(w_cross), .area(area_mag), .weight(ww)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Carry the zero-area flag alongside the divider lanes
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            deg_reg[0] <= (area_cross == '0);
            for (int i = 1; i < LDIV; i++)
                deg_reg[i] <= deg_reg[i-1];
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tuser  = deg_reg[LDIV-1];
    assign m_axis_tdata  = deg_reg[LDIV-1] ? '0 : {ww, wv, wu};

`ifndef ASSERT_OFF
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
        else $error("ready does not follow output stall");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("degenerate result carries non-zero weights");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ce && vld_reg[LAT-2]) |=> m_axis_tvalid)
        else $error("result lost in last stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(vld_reg[0]))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

### dv/triangle_barycentric_coords_unit_tb.sv
// Stream testbench for the barycentric coordinate unit with a self-checking weight predictor.
`default_nettype none

module triangle_barycentric_coords_unit_tb;

    localparam int CB        = 16;
    localparam int WATCHDOG  = 20000;
    localparam int DRAIN     = 40;

    typedef struct packed {
        logic [bcc_pkg::WEIGHT_BITS-1:0] w;
        logic [bcc_pkg::WEIGHT_BITS-1:0] v;
        logic [bcc_pkg::WEIGHT_BITS-1:0] u;
        logic                            degen;
    } weights_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [8*CB-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [3*bcc_pkg::WEIGHT_BITS-1:0] m_axis_tdata;
    logic              m_axis_tuser;

    weights_t weights_due[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_off_cycles;
    int       quiet_cycles;
    int       fail_count;

    triangle_barycentric_coords_unit #(.COORD_BITS(CB)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [63:0] cross_2d(logic signed [63:0] x0, logic signed [63:0] z0,
                                                   logic signed [63:0] x1, logic signed [63:0] z1);
        return x0 * z1 - z0 * x1;
    endfunction

    // Truncate toward zero, then clamp to Q4.12
    function automatic logic [bcc_pkg::WEIGHT_BITS-1:0] scaled_weight(logic signed [63:0] num,
                                                                      logic signed [63:0] area);
        logic signed [63:0] q;
        q = (num * 64'sd4096) / area;
        if (q > 64'sd32767)
            return bcc_pkg::WEIGHT_MAX;
        if (q < -64'sd32768)
            return bcc_pkg::WEIGHT_MIN;
        return q[bcc_pkg::WEIGHT_BITS-1:0];
    endfunction

    function automatic weights_t predict_weights(logic [8*CB-1:0] tri_data);
        logic signed [63:0] c [8];
        logic signed [63:0] area;
        weights_t r;
        for (int i = 0; i < 8; i++)
            c[i] = 64'(signed'(tri_data[i*CB +: CB]));
        area = cross_2d(c[4] - c[2], c[5] - c[3], c[6] - c[2], c[7] - c[3]);
        if (area < 0)
            area = -area;
        r = '0;
        if (area == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        r.u = scaled_weight(cross_2d(c[4] - c[0], c[5] - c[1], c[6] - c[0], c[7] - c[1]), area);
        r.v = scaled_weight(cross_2d(c[6] - c[0], c[7] - c[1], c[2] - c[0], c[3] - c[1]), area);
        r.w = scaled_weight(cross_2d(c[2] - c[0], c[3] - c[1], c[4] - c[0], c[5] - c[1]), area);
        return r;
    endfunction

    // Enter and leave at a falling edge; valid stays high between back-to-back requests
    task automatic send_triangle(logic [8*CB-1:0] tri_data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tri_data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        weights_due.push_back(predict_weights(tri_data));
        @(negedge clk);
    endtask

    function automatic logic [CB-1:0] rand_coord(int spread);
        case (spread)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 2047)) - CB'(1024);
            default: return CB'($urandom_range(0, 15)) - CB'(8);
        endcase
    endfunction

    task automatic send_random(int count);
        logic [8*CB-1:0] d;
        int spread;
        for (int n = 0; n < count; n++)
        begin
            spread = $urandom_range(0, 2);
            for (int i = 0; i < 8; i++)
                d[i*CB +: CB] = rand_coord(spread);
            // Sometimes put the point on a vertex or make the triangle collinear
            if ($urandom_range(0, 9) == 0)
                d[0 +: 2*CB] = d[(2*$urandom_range(1, 3))*CB +: 2*CB];
            if ($urandom_range(0, 14) == 0)
                d[6*CB +: 2*CB] = d[4*CB +: 2*CB];
            send_triangle(d);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (weights_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [8*CB-1:0] pack_tri(int px, int pz, int ax, int az,
                                                 int bx, int bz, int cx, int cz);
        return {CB'(cz), CB'(cx), CB'(bz), CB'(bx), CB'(az), CB'(ax), CB'(pz), CB'(px)};
    endfunction

    task automatic test_directed();
        send_triangle(pack_tri(64, 64, 0, 0, 256, 0, 0, 256));
        send_triangle(pack_tri(0, 0, 0, 0, 256, 0, 0, 256));
        send_triangle(pack_tri(256, 0, 0, 0, 256, 0, 0, 256));
        send_triangle(pack_tri(0, 0, 0, 0, 0, 256, 256, 0));
        send_triangle(pack_tri(5, 5, 0, 0, 0, 0, 0, 0));
        send_triangle(pack_tri(1, 1, 0, 0, 256, 256, 512, 512));
        send_triangle(pack_tri(32767, 32767, 0, 0, 1, 0, 0, 1));
        send_triangle(pack_tri(-32768, -32768, 0, 0, 1, 0, 0, 1));
        send_triangle(pack_tri(-32768, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_triangle(pack_tri(32767, 32767, 32767, 32767, -32768, 32767, 32767, -32768));
        send_triangle(pack_tri(-32768, -32768, -32768, -32768, 32767, 32767, -32768, 32767));
        send_triangle(pack_tri(0, 0, -32768, -32768, 32767, -32768, 32767, 32767));
        send_triangle(pack_tri(-1, -1, -1, -1, -1, -1, -1, -1));
        send_triangle(pack_tri(0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(pack_tri(2048, 2048, 0, 0, 256, 0, 0, 256));
        send_triangle(pack_tri(-2048, 0, 0, 0, 256, 0, 0, 256));
        send_triangle(pack_tri(100, -300, 7, 9, -500, 1200, 800, -77));
        send_triangle(pack_tri(21845, -21846, 21845, -21846, -21846, 21845, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_phases();
        send_idle_pct = 12;
        recv_idle_pct = 62;
        send_random(600);
        send_idle_pct = 62;
        recv_idle_pct = 12;
        send_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(500);
    endtask

    task automatic test_backpressure();
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 200;
        send_random(60);
        // Pause the sender until every request has been answered
        wait_drained();
        send_random(40);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        weights_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (weights_due.size() == 0)
            begin
                $error("result with nothing outstanding: tdata=%h tuser=%b",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                exp_w = weights_due.pop_front();
                if (m_axis_tdata[0 +: bcc_pkg::WEIGHT_BITS] !== exp_w.u)
                begin
                    $error("weight_u expected %h actual %h", exp_w.u, m_axis_tdata[0 +: 16]);
                    fail_count++;
                end
                if (m_axis_tdata[bcc_pkg::WEIGHT_BITS +: bcc_pkg::WEIGHT_BITS] !== exp_w.v)
                begin
                    $error("weight_v expected %h actual %h", exp_w.v, m_axis_tdata[16 +: 16]);
                    fail_count++;
                end
                if (m_axis_tdata[2*bcc_pkg::WEIGHT_BITS +: bcc_pkg::WEIGHT_BITS] !== exp_w.w)
                begin
                    $error("weight_w expected %h actual %h", exp_w.w, m_axis_tdata[32 +: 16]);
                    fail_count++;
                end
                if (m_axis_tuser !== exp_w.degen)
                begin
                    $error("degenerate expected %b actual %b", exp_w.degen, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("[triangle_barycentric_coords_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        quiet_cycles    = 0;
        fail_count      = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        wait_drained();
        repeat (DRAIN) @(negedge clk);
        if (fail_count == 0 && weights_due.size() == 0)
            $display("[triangle_barycentric_coords_unit] OK");
        else
            $display("[triangle_barycentric_coords_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
